/* sv/ballbot_lqr_state_feedback_assert.svh */
// Assertion macros for the ballbot LQR controller.
// Used by the top level; expects signals clk and rst in scope.
`ifndef BALLBOT_LQR_STATE_FEEDBACK_ASSERT_SVH
`define BALLBOT_LQR_STATE_FEEDBACK_ASSERT_SVH

// same-cycle implication
`define BLSF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define BLSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* sv/blsf_pkg.sv */
// Shared constants, register indexes and fixed-point helpers of the
// ballbot LQR controller. No dependencies.
package blsf_pkg;

  localparam int unsigned PW = 90;

  localparam logic signed [24:0] K_TWO_PI = 25'sd25736;
  localparam logic signed [24:0] K_MIX_A  = 25'sd61788;
  localparam logic signed [24:0] K_MIX_B  = 25'sd30893;
  localparam logic signed [24:0] K_MIX_Y  = 25'sd53509;
  localparam logic signed [24:0] K_SQRT3  = 25'sd113515;

  localparam logic [3:0] REG_GAIN_TILT_X      = 4'd0;
  localparam logic [3:0] REG_GAIN_TILT_RATE_X = 4'd1;
  localparam logic [3:0] REG_GAIN_TILT_Y      = 4'd2;
  localparam logic [3:0] REG_GAIN_TILT_RATE_Y = 4'd3;
  localparam logic [3:0] REG_GAIN_ROLL_X      = 4'd4;
  localparam logic [3:0] REG_GAIN_ROLL_RATE_X = 4'd5;
  localparam logic [3:0] REG_GAIN_ROLL_Y      = 4'd6;
  localparam logic [3:0] REG_GAIN_ROLL_RATE_Y = 4'd7;

  typedef logic signed [PW-1:0] wide_t;

  // shift right, rounding toward zero
  function automatic wide_t trunc_shr(input wide_t v, input int unsigned sh);
    wide_t bias;
    bias = (wide_t'(1) <<< sh) - wide_t'(1);
    return (v + (v[PW-1] ? bias : wide_t'(0))) >>> sh;
  endfunction

  // clamp to [-2^lb, 2^lb - 1]
  function automatic wide_t clamp_s(input wide_t v, input int unsigned lb);
    wide_t lim;
    lim = wide_t'(1) <<< lb;
    if (v > lim - wide_t'(1)) return lim - wide_t'(1);
    if (v < -lim) return -lim;
    return v;
  endfunction

endpackage

/* sv/blsf_mul.sv */
// Bit-serial signed multiplier: one multiplier bit per cycle.
// Depends on blsf_pkg for the product width.
module blsf_mul import blsf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [24:0] b,
  output logic               done,
  output wide_t              p
);

  logic [64:0] hi;
  logic [24:0] lo;
  logic [4:0]  cnt;
  logic        neg;
  logic        busy;
  logic        fin;
  logic [63:0] amag;
  logic [64:0] sum;

  assign sum = hi + (lo[0] ? {1'b0, amag} : 65'd0);

  always_ff @(posedge clk) begin
    done <= !rst && !start && !busy && fin;
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else if (start) begin
      amag <= a[63] ? 64'(-a) : 64'(a);
      lo   <= b[24] ? 25'(-b) : 25'(b);
      hi   <= 65'd0;
      neg  <= a[63] ^ b[24];
      cnt  <= 5'd0;
      busy <= 1'b1;
    end else if (busy) begin
      hi  <= {1'b0, sum[64:1]};
      lo  <= {sum[0], lo[24:1]};
      cnt <= cnt + 5'd1;
      if (cnt == 5'd24) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end else if (fin) begin
      p    <= neg ? -wide_t'({hi, lo}) : wide_t'({hi, lo});
      fin  <= 1'b0;
    end
  end

endmodule

/* sv/blsf_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
// No dependencies.
module blsf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [46:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [46:0] q
);

  logic [16:0] rem;
  logic [16:0] trial;
  logic [15:0] dv;
  logic [5:0]  cnt;
  logic        busy;
  logic        ge;

  assign trial = {rem[15:0], q[46]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (cnt == 6'd46);
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      q    <= dividend;
      dv   <= divisor;
      rem  <= 17'd0;
      cnt  <= 6'd0;
      busy <= 1'b1;
    end else if (busy) begin
      rem <= ge ? trial - {1'b0, dv} : trial;
      q   <= {q[45:0], ge};
      cnt <= cnt + 6'd1;
      if (cnt == 6'd46) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* sv/ballbot_lqr_state_feedback.sv */
// Top level of the ballbot LQR state-feedback controller: sequencer,
// gain registers and state. Depends on blsf_pkg, blsf_mul, blsf_div.
//
// Use: one input word per control tick on the s_ channel carries three
// wheel encoder counts and two tilt angles; one output word on the m_
// channel carries three saturated wheel drives, with the saturation flag
// in m_tuser. Gains are written on the cfg_ channel; the user must write
// them only while idle, as the block does not enforce it. cfg_ready is
// always high and indexes above seven are dropped.
// Each word runs through 27 multiplies on a bit-serial multiplier
// (one multiplier bit per cycle) and three divides on a restoring
// divider, and one word is in work at a time. s_tready is high only
// while idle.
// A finished result waits in the output register; the next word is
// accepted while it waits, and a second result holds in the sequencer
// until m_tready takes the first.
// Reset (synchronous, rst high) loads the default gains, clears the
// stored tilts and roll angles and empties the output register.
module ballbot_lqr_state_feedback import blsf_pkg::*; #(
  parameter int unsigned COUNTS_PER_TURN  = 1452,
  parameter int unsigned TICKS_PER_SECOND = 200,
  parameter int unsigned DRIVE_SCALE      = 1200
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // wheel_count_a, wheel_count_b, wheel_count_c, tilt_x, tilt_y
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // drive_a, drive_b, drive_c
  output logic [47:0]  m_tdata,
  // clipped
  output logic         m_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_DIV, S_OUT} state_t;
  typedef enum logic [4:0] {
    ST_PSI_A, ST_PSI_B, ST_PSI_C, ST_PHIX_A, ST_PHIX_B, ST_PHIX_C,
    ST_PHIY_C, ST_PHIY_B, ST_DPHIX, ST_DPHIY, ST_DTX, ST_DTY,
    ST_TQX_0, ST_TQX_1, ST_TQX_2, ST_TQX_3, ST_TQY_0, ST_TQY_1, ST_TQY_2, ST_TQY_3,
    ST_SQ3, ST_DA, ST_SA, ST_DB, ST_SB, ST_DC, ST_SC
  } step_t;

  state_t st;
  step_t  step;

  logic signed [31:0] in_a, in_b, in_c;
  logic signed [15:0] in_tx, in_ty;
  logic signed [23:0] g_tx, g_tdx, g_ty, g_tdy, g_rx, g_rdx, g_ry, g_rdy;
  logic signed [15:0] last_tilt_x, last_tilt_y;
  logic signed [39:0] last_roll_x, last_roll_y;
  logic signed [63:0] psi_a, psi_b, psi_c, tqx, sb, sc, dv;
  logic signed [39:0] phix, phiy, dphix, dphiy, dtx, dty;
  wide_t              acc;
  logic               div_neg;
  logic signed [15:0] drv_a, drv_b, drv_c;
  logic               clip;

  logic               mul_start, mul_done, div_start, div_done;
  logic               step_psi, out_load;
  logic signed [63:0] op_a;
  logic signed [24:0] op_b;
  wide_t              mul_p, p_mag, t12, t16, acc_sub, acc_add, drv_x;
  logic [46:0]        div_q;
  logic signed [63:0] psi_new, tq_neg, m_sq3;
  logic signed [15:0] drv_sat;
  logic               drv_clip;

  assign s_tready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mul_start = (st == S_ISSUE);
  assign step_psi  = (step == ST_PSI_A || step == ST_PSI_B || step == ST_PSI_C);
  assign div_start = (st == S_WAIT) && mul_done && step_psi;
  assign out_load  = (st == S_OUT) && (!m_tvalid || m_tready);

  assign p_mag   = mul_p[PW-1] ? -mul_p : mul_p;
  assign t12     = trunc_shr(mul_p, 12);
  assign t16     = trunc_shr(mul_p, 16);
  assign acc_sub = acc - mul_p;
  assign acc_add = acc + t12;
  assign tq_neg  = 64'(-acc_add);
  assign m_sq3   = 64'(t16);
  assign psi_new = div_neg ? -64'(div_q) : 64'(div_q);
  assign drv_x   = trunc_shr(mul_p, 12);

  always_comb begin
    drv_clip = 1'b0;
    drv_sat  = 16'(drv_x);
    if (drv_x > wide_t'(32767)) begin
      drv_sat  = 16'sh7fff;
      drv_clip = 1'b1;
    end else if (drv_x < -wide_t'(32768)) begin
      drv_sat  = 16'sh8000;
      drv_clip = 1'b1;
    end
  end

  always_comb begin
    op_a = 64'(in_a);
    op_b = K_TWO_PI;
    case (step)
      ST_PSI_A:  begin op_a = 64'(in_a); op_b = K_TWO_PI; end
      ST_PSI_B:  begin op_a = 64'(in_b); op_b = K_TWO_PI; end
      ST_PSI_C:  begin op_a = 64'(in_c); op_b = K_TWO_PI; end
      ST_PHIX_A: begin op_a = psi_a; op_b = K_MIX_A; end
      ST_PHIX_B: begin op_a = psi_b; op_b = K_MIX_B; end
      ST_PHIX_C: begin op_a = psi_c; op_b = K_MIX_B; end
      ST_PHIY_C: begin op_a = psi_c; op_b = K_MIX_Y; end
      ST_PHIY_B: begin op_a = psi_b; op_b = K_MIX_Y; end
      ST_DPHIX: begin
        op_a = 64'(41'(phix) - 41'(last_roll_x)); op_b = 25'(TICKS_PER_SECOND);
      end
      ST_DPHIY: begin
        op_a = 64'(41'(phiy) - 41'(last_roll_y)); op_b = 25'(TICKS_PER_SECOND);
      end
      ST_DTX: begin
        op_a = 64'(17'(in_tx) - 17'(last_tilt_x)); op_b = 25'(TICKS_PER_SECOND);
      end
      ST_DTY: begin
        op_a = 64'(17'(in_ty) - 17'(last_tilt_y)); op_b = 25'(TICKS_PER_SECOND);
      end
      ST_TQX_0: begin op_a = 64'(in_tx); op_b = 25'(g_tx); end
      ST_TQX_1: begin op_a = 64'(dtx);   op_b = 25'(g_tdx); end
      ST_TQX_2: begin op_a = 64'(phix);  op_b = 25'(g_rx); end
      ST_TQX_3: begin op_a = 64'(dphix); op_b = 25'(g_rdx); end
      ST_TQY_0: begin op_a = 64'(in_ty); op_b = 25'(g_ty); end
      ST_TQY_1: begin op_a = 64'(dty);   op_b = 25'(g_tdy); end
      ST_TQY_2: begin op_a = 64'(phiy);  op_b = 25'(g_ry); end
      ST_TQY_3: begin op_a = 64'(dphiy); op_b = 25'(g_rdy); end
      ST_SQ3:   begin op_a = 64'(acc); op_b = K_SQRT3; end
      ST_DA:    begin op_a = tqx; op_b = K_MIX_A; end
      ST_DB:    begin op_a = sb;  op_b = K_MIX_B; end
      ST_DC:    begin op_a = sc;  op_b = K_MIX_B; end
      ST_SA, ST_SB, ST_SC: begin
        op_a = 64'(clamp_s(wide_t'(dv), 44)); op_b = 25'(DRIVE_SCALE);
      end
      default: ;
    endcase
  end

  blsf_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(op_a), .b(op_b),
    .done(mul_done), .p(mul_p)
  );

  blsf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(p_mag[46:0]),
    .divisor(16'(COUNTS_PER_TURN)), .done(div_done), .q(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      step        <= ST_PSI_A;
      m_tvalid    <= 1'b0;
      g_tx        <= -24'sd167743;
      g_tdx       <= -24'sd8962;
      g_ty        <= -24'sd167744;
      g_tdy       <= -24'sd8966;
      g_rx        <= -24'sd1629;
      g_rdx       <= -24'sd3493;
      g_ry        <= -24'sd1629;
      g_rdy       <= -24'sd3490;
      last_tilt_x <= '0;
      last_tilt_y <= '0;
      last_roll_x <= '0;
      last_roll_y <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_GAIN_TILT_X:      g_tx  <= cfg_data;
          REG_GAIN_TILT_RATE_X: g_tdx <= cfg_data;
          REG_GAIN_TILT_Y:      g_ty  <= cfg_data;
          REG_GAIN_TILT_RATE_Y: g_tdy <= cfg_data;
          REG_GAIN_ROLL_X:      g_rx  <= cfg_data;
          REG_GAIN_ROLL_RATE_X: g_rdx <= cfg_data;
          REG_GAIN_ROLL_Y:      g_ry  <= cfg_data;
          REG_GAIN_ROLL_RATE_Y: g_rdy <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            in_a  <= s_tdata[31:0];
            in_b  <= s_tdata[63:32];
            in_c  <= s_tdata[95:64];
            in_tx <= s_tdata[111:96];
            in_ty <= s_tdata[127:112];
            clip  <= 1'b0;
            step  <= ST_PSI_A;
            st    <= S_ISSUE;
          end
        end
        S_ISSUE: st <= S_WAIT;
        S_WAIT: begin
          if (mul_done) begin
            if (step_psi) begin
              st <= S_DIV;
            end else if (step == ST_SC) begin
              st <= S_OUT;
            end else begin
              st   <= S_ISSUE;
              step <= step_t'(step + 5'd1);
            end
            case (step)
              ST_PSI_A, ST_PSI_B, ST_PSI_C: div_neg <= mul_p[PW-1];
              ST_PHIX_A: acc <= mul_p;
              ST_PHIX_B: acc <= acc_sub;
              ST_PHIX_C: phix <= 40'(clamp_s(trunc_shr(acc_sub, 16), 39));
              ST_PHIY_C: acc <= mul_p;
              ST_PHIY_B: phiy <= 40'(clamp_s(trunc_shr(acc_sub, 16), 39));
              ST_DPHIX: dphix <= 40'(clamp_s(mul_p, 39));
              ST_DPHIY: dphiy <= 40'(clamp_s(mul_p, 39));
              ST_DTX:   dtx   <= 40'(clamp_s(mul_p, 39));
              ST_DTY:   dty   <= 40'(clamp_s(mul_p, 39));
              ST_TQX_0, ST_TQY_0: acc <= t12;
              ST_TQX_1, ST_TQX_2, ST_TQY_1, ST_TQY_2: acc <= acc_add;
              ST_TQX_3: tqx <= tq_neg;
              ST_TQY_3: begin end
              ST_SQ3: begin
                sb <= -tqx - m_sq3;
                sc <= -tqx + m_sq3;
              end
              ST_DA, ST_DB, ST_DC: dv <= 64'(t16);
              ST_SA: begin drv_a <= drv_sat; clip <= clip | drv_clip; end
              ST_SB: begin drv_b <= drv_sat; clip <= clip | drv_clip; end
              ST_SC: begin
                drv_c       <= drv_sat;
                clip        <= clip | drv_clip;
                last_roll_x <= phix;
                last_roll_y <= phiy;
                last_tilt_x <= in_tx;
                last_tilt_y <= in_ty;
              end
              default: ;
            endcase
            // tqy feeds the sqrt3 product directly
            if (step == ST_TQY_3) acc <= wide_t'(tq_neg);
          end
        end
        S_DIV: begin
          if (div_done) begin
            case (step)
              ST_PSI_A: psi_a <= psi_new;
              ST_PSI_B: psi_b <= psi_new;
              default:  psi_c <= psi_new;
            endcase
            step <= step_t'(step + 5'd1);
            st   <= S_ISSUE;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_tdata[15:0]  <= drv_a;
            m_tdata[31:16] <= drv_b;
            m_tdata[47:32] <= drv_c;
            m_tuser        <= clip;
            st             <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

`include "ballbot_lqr_state_feedback_assert.svh"

  `BLSF_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `BLSF_ASSERT_IMP(a_mul_done_in_wait, mul_done, st == S_WAIT)
  `BLSF_ASSERT_IMP(a_div_done_in_div, div_done, st == S_DIV)
  `BLSF_ASSERT_NEXT(a_out_loads_valid, st == S_OUT && (!m_tvalid || m_tready), m_tvalid)

endmodule
